// ----- rtl/ovl_pkg.sv -----
package ovl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;
	localparam logic [1:0] ACT_SHOW   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FOUND     = 3'd4;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]                status;
		logic signed [VALUE_W-1:0] entry_value;
		logic                      last;
	} res_t;

endpackage

// ----- rtl/ovl_ram.sv -----
module ovl_ram #(
	parameter int WIDTH = ovl_pkg::VALUE_W,
	parameter int DEPTH = ovl_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ordered_value_list.sv -----
// Bounded list of signed 32-bit values in insertion order, held in one RAM.
// A command is taken when start is high and busy is low; each result beat is
// shown for one cycle with strobe high and cannot be held off. Insert, and
// any command on an empty list, finishes in the cycle it is taken (busy stays
// low) with its result registered into the next cycle. Search and show walk
// the stored entries one per cycle through the RAM read port and the single
// compare. Delete walks to the first match, then closes the gap one entry
// per cycle over the same port. Show gives one beat per entry, last set on
// the final one.
module ordered_value_list #(
	parameter int DEPTH = ovl_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ovl_pkg::cmd_t cmd,
	output logic          strobe,
	output ovl_pkg::res_t result
);
	import ovl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [1:0]         state_q, state_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [1:0]         op_q, op_d;
	logic [VALUE_W-1:0] key_q, key_d;
	logic               vld_s1, vld_d;
	logic [AW-1:0]      addr_s1;
	logic               strobe_q;
	res_t               result_q;

	logic               emit;
	res_t               emit_res;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic [VALUE_W-1:0] rdata;
	logic               issue;
	logic               hit;
	logic               tail;

	ovl_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	assign issue = idx_q < cnt_q;
	assign hit   = rdata == key_q;
	assign tail  = CW'(addr_s1) == (cnt_q - CW'(1));

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		op_d     = op_q;
		key_d    = key_q;
		vld_d    = 1'b0;
		emit     = 1'b0;
		emit_res = '0;
		we       = 1'b0;
		waddr    = cnt_q[AW-1:0];
		wdata    = cmd.value;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d  = cmd.action;
					key_d = cmd.value;
					idx_d = '0;
					if (cmd.action == ACT_INSERT) begin
						emit          = 1'b1;
						emit_res.last = 1'b1;
						if (cnt_q == CW'(DEPTH)) begin
							emit_res.status = ST_FULL;
						end else begin
							we              = 1'b1;
							cnt_d           = cnt_q + CW'(1);
							emit_res.status = ST_OK;
						end
					end else if (cnt_q == '0) begin
						emit            = 1'b1;
						emit_res.last   = 1'b1;
						emit_res.status = ST_EMPTY;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				vld_d = issue;
				if (issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (vld_s1) begin
					case (op_q)
						ACT_SHOW: begin
							emit                 = 1'b1;
							emit_res.status      = ST_OK;
							emit_res.entry_value = rdata;
							emit_res.last        = tail;
							if (tail) begin
								state_d = S_IDLE;
							end
						end
						ACT_SEARCH: begin
							if (hit || tail) begin
								emit            = 1'b1;
								emit_res.last   = 1'b1;
								emit_res.status = hit ? ST_FOUND : ST_NOT_FOUND;
								state_d         = S_IDLE;
							end
						end
						default: begin
							if (hit) begin
								state_d = S_SHIFT;
								idx_d   = CW'(addr_s1) + CW'(1);
							end else if (tail) begin
								emit            = 1'b1;
								emit_res.last   = 1'b1;
								emit_res.status = ST_NOT_FOUND;
								state_d         = S_IDLE;
							end
						end
					endcase
				end
				if (state_d != S_SCAN) begin
					vld_d = 1'b0;
				end
			end
			S_SHIFT: begin
				vld_d = issue;
				if (issue) begin
					idx_d = idx_q + CW'(1);
				end
				if (vld_s1) begin
					we    = 1'b1;
					waddr = addr_s1 - AW'(1);
					wdata = rdata;
				end
				if (!issue && !vld_s1) begin
					cnt_d           = cnt_q - CW'(1);
					emit            = 1'b1;
					emit_res.last   = 1'b1;
					emit_res.status = ST_OK;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
			vld_s1   <= vld_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		key_q    <= key_d;
		addr_s1  <= idx_q[AW-1:0];
		result_q <= emit_res;
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- rtl/ovl_checker.sv -----
module ovl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ovl_pkg::cmd_t cmd,
	input logic          strobe,
	input ovl_pkg::res_t result
);
	import ovl_pkg::*;

	// insert always answers with a single final beat next cycle
	a_insert_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == ACT_INSERT |=> strobe && result.last)
		else $error("insert gave no final beat");

	// a walking command either goes busy or was answered as empty
	a_walk_or_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action != ACT_INSERT
		|=> busy || (strobe && result.last && result.status == ST_EMPTY))
		else $error("walking command neither busy nor empty");

	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("command ended without final beat");

	a_more_beats: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final beat while idle");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.entry_value == '0)
		else $error("status beat carries a value");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.strobe(strobe),
	.result(result)
);
